FILE: design/wam_pkg.sv
// Shared constants, types and helpers for the wildcard address matcher.
`timescale 1ns / 1ps

package wam_pkg;

    localparam int MASK_CHARS = 64;
    localparam int POS_COUNT  = MASK_CHARS + 1;
    localparam int LEN_W      = $clog2(MASK_CHARS + 1);
    localparam int IDX_W      = $clog2(MASK_CHARS);

    localparam logic [7:0] STAR_CODE  = 8'h2A;
    localparam logic [7:0] QMARK_CODE = 8'h3F;

    typedef enum logic [1:0] {
        KIND_MASK_CHAR = 2'd0,
        KIND_MASK_END  = 2'd1,
        KIND_ADDR_CHAR = 2'd2,
        KIND_ADDR_END  = 2'd3
    } t_kind;

    typedef logic [POS_COUNT-1:0] t_pos_vec;
    typedef logic [7:0] t_char_arr [MASK_CHARS];

    // per-entry decode of the stored mask
    typedef struct packed {
        logic [MASK_CHARS-1:0] star;
        logic [MASK_CHARS-1:0] qmark;
        logic [MASK_CHARS-1:0] live;   // entry lies below the mask length
    } t_mask_flags;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: design/wam_mask_store.sv
// Mask character cells: upper-cased storage plus per-entry decode.
`timescale 1ns / 1ps

module wam_mask_store
    import wam_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [7:0]        i_wr_char,
    input  logic [LEN_W-1:0]  i_len,
    output t_char_arr         o_chars,
    output t_mask_flags       o_flags
);

    logic [7:0] r_chars [MASK_CHARS];

    // written at one place per cycle, no reset: entries past the length are never used
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_chars[i_wr_idx] <= upcase(i_wr_char);
        end
    end

    always_comb begin
        for (int i = 0; i < MASK_CHARS; i++) begin
            o_chars[i]       = r_chars[i];
            o_flags.star[i]  = (r_chars[i] == STAR_CODE);
            o_flags.qmark[i] = (r_chars[i] == QMARK_CODE);
            o_flags.live[i]  = (LEN_W'(i) < i_len);
        end
    end

endmodule

FILE: design/wam_position_update.sv
// Next active-position vector: one character step or restart, then star closure.
`timescale 1ns / 1ps

module wam_position_update
    import wam_pkg::*;
(
    input  t_pos_vec     i_active,
    input  logic         i_restart,
    input  logic [7:0]   i_char,
    input  t_char_arr    i_chars,
    input  t_mask_flags  i_flags,
    output t_pos_vec     o_next
);

    localparam int LEVELS = $clog2(POS_COUNT);

    always_comb begin
        logic [7:0] uc;
        t_pos_vec   stepped;
        t_pos_vec   g;
        t_pos_vec   p;
        t_pos_vec   g_n;
        t_pos_vec   p_n;
        int         d;

        uc = upcase(i_char);

        // star keeps its own position, any other hit moves one right
        stepped = '0;
        for (int i = 0; i < MASK_CHARS; i++) begin
            if (i_active[i] && i_flags.live[i]) begin
                if (i_flags.star[i]) begin
                    stepped[i] = 1'b1;
                end else if (i_flags.qmark[i] || i_chars[i] == uc) begin
                    stepped[i+1] = 1'b1;
                end
            end
        end

        g = i_restart ? t_pos_vec'(1) : stepped;

        // propagate from position i to i+1 across a live star
        p = '0;
        for (int j = 1; j < POS_COUNT; j++) begin
            p[j] = i_flags.live[j-1] & i_flags.star[j-1];
        end

        // log-depth OR prefix over runs of stars
        for (int l = 0; l < LEVELS; l++) begin
            d   = 1 << l;
            g_n = g;
            p_n = '0;
            for (int j = 0; j < POS_COUNT; j++) begin
                if (j >= d) begin
                    g_n[j] = g[j] | (p[j] & g[j-d]);
                    p_n[j] = p[j] & p[j-d];
                end
            end
            g = g_n;
            p = p_n;
        end

        o_next = g;
    end

endmodule

FILE: design/wildcard_address_match_top.sv
// Top level of the case-insensitive wildcard address matcher.
`timescale 1ns / 1ps

// Usage:
//   Items arrive on the slave stream: tuser carries the kind (mask char,
//   mask end, address char, address end), tdata the character byte.
//   A mask is loaded one char per item and closed by mask end; address
//   chars then step a bit vector of live mask positions ('*' any run,
//   '?' one char, other chars compared after ASCII upper-casing).
//   Only an address-end item yields a result on the master stream:
//   tdata[0] = matched, tuser[0] = mask overflow (mask longer than the
//   64-entry store; matched is then 0).
//   Throughput: one item per cycle while no address-end item waits on the
//   output. Each item is held in the input register and then applied to the
//   state; the position update (parallel compare plus a log-depth star
//   closure) lies between them. An address-end item's result passes the
//   input register and then the result register before the master stream.
//   Stall: the output register holds a result until taken; while it is
//   full and not taken, an address-end item waits in the input register,
//   other kinds keep flowing.
//   Reset (synchronous, active low): empty open mask, no overflow,
//   position zero live, both streams empty. No clearing pass is needed.

module wildcard_address_match_top
    import wam_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_code
    input  logic [1:0] i_s_axis_tuser,   // [1:0] kind
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [0] matched, [7:1] zero
    output logic       o_m_axis_tuser    // [0] mask_overflow
);

    // input register
    logic       r_in_vld;
    t_kind      r_in_kind;
    logic [7:0] r_in_char;

    // block state
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic             r_closed;
    t_pos_vec         r_active;

    // result register
    logic r_out_vld;
    logic r_out_match;
    logic r_out_ovf;

    logic             proc_go;
    logic [LEN_W-1:0] eff_len;
    logic             wr_en;
    logic             upd_en;
    t_char_arr        mask_chars;
    t_mask_flags      mask_flags;
    t_pos_vec         next_active;

    // an address-end item needs room in the result register
    assign proc_go = r_in_vld
                   && (r_in_kind != KIND_ADDR_END || !r_out_vld || i_m_axis_tready);

    assign o_s_axis_tready = !r_in_vld || proc_go;

    // a mask char after close opens a new mask from entry zero
    assign eff_len = (r_in_kind == KIND_MASK_CHAR && r_closed) ? '0 : r_len;
    assign wr_en   = proc_go && r_in_kind == KIND_MASK_CHAR
                   && eff_len < LEN_W'(MASK_CHARS);

    assign upd_en = proc_go && (r_in_kind == KIND_MASK_END
                   || (r_closed && (r_in_kind == KIND_ADDR_CHAR
                                    || r_in_kind == KIND_ADDR_END)));

    wam_mask_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (eff_len[IDX_W-1:0]),
        .i_wr_char (r_in_char),
        .i_len     (r_len),
        .o_chars   (mask_chars),
        .o_flags   (mask_flags)
    );

    wam_position_update u_update (
        .i_active  (r_active),
        .i_restart (r_in_kind != KIND_ADDR_CHAR),
        .i_char    (r_in_char),
        .i_chars   (mask_chars),
        .i_flags   (mask_flags),
        .o_next    (next_active)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_closed  <= 1'b0;
            r_active  <= t_pos_vec'(1);
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end

            if (proc_go) begin
                case (r_in_kind)
                    KIND_MASK_CHAR: begin
                        r_closed <= 1'b0;
                        if (eff_len < LEN_W'(MASK_CHARS)) begin
                            r_len <= eff_len + LEN_W'(1);
                            r_ovf <= r_ovf && !r_closed;
                        end else begin
                            r_len <= eff_len;
                            r_ovf <= 1'b1;
                        end
                    end
                    KIND_MASK_END: begin
                        r_closed <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            if (upd_en) begin
                r_active <= next_active;
            end

            if (proc_go && r_in_kind == KIND_ADDR_END) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_kind <= t_kind'(i_s_axis_tuser);
            r_in_char <= i_s_axis_tdata;
        end
        if (proc_go && r_in_kind == KIND_ADDR_END) begin
            r_out_match <= r_closed && !r_ovf && r_active[r_len];
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out_match};
    assign o_m_axis_tuser  = r_out_ovf;

endmodule
